[rtl/lscal_pkg.sv]
// Shared types, constants and helpers for the least-squares line calibrator.
package lscal_pkg;

	localparam int unsigned MAX_POINTS = 16;
	localparam int unsigned TOT_W      = $clog2(MAX_POINTS + 1);
	localparam int unsigned PROD_W     = 100;
	localparam int unsigned MUL_A_W    = 64;
	localparam int unsigned MUL_B_W    = 36;
	localparam int unsigned DEN_W      = 58;

	localparam logic [2:0] ACT_ADD   = 3'd0;
	localparam logic [2:0] ACT_RESET = 3'd1;
	localparam logic [2:0] ACT_FIT   = 3'd2;
	localparam logic [2:0] ACT_CONV  = 3'd3;
	localparam logic [2:0] ACT_LOAD  = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_FEW   = 2'd2;
	localparam logic [1:0] ST_DEN0  = 2'd3;

	localparam logic [2:0] M_CW    = 3'd0;
	localparam logic [2:0] M_CC    = 3'd1;
	localparam logic [2:0] M_NC2   = 3'd2;
	localparam logic [2:0] M_SCSC  = 3'd3;
	localparam logic [2:0] M_NCW   = 3'd4;
	localparam logic [2:0] M_SCSW  = 3'd5;
	localparam logic [2:0] M_SLSC  = 3'd6;
	localparam logic [2:0] M_SLCNT = 3'd7;

	localparam logic [2:0] A_SCW   = 3'd0;
	localparam logic [2:0] A_ADDPT = 3'd1;
	localparam logic [2:0] A_T1    = 3'd2;
	localparam logic [2:0] A_T1SUB = 3'd3;
	localparam logic [2:0] A_T2    = 3'd4;
	localparam logic [2:0] A_T2SUB = 3'd5;
	localparam logic [2:0] A_IC    = 3'd6;
	localparam logic [2:0] A_CV    = 3'd7;

	localparam logic [1:0] D_SLOPE = 2'd0;
	localparam logic [1:0] D_ICPT  = 2'd1;

	typedef struct packed {
		logic       cap;
		logic       mul_go;
		logic [2:0] mul_sel;
		logic       acc_en;
		logic [2:0] acc_op;
		logic       div_go;
		logic [1:0] div_sel;
		logic       conv;
		logic       set_st;
		logic [1:0] st;
		logic       clr_tot;
		logic       load;
		logic       pub;
	} cmd_t;

	typedef struct packed {
		logic [2:0] action;
		logic       mdone;
		logic       ddone;
		logic       full;
		logic       few;
		logic       den0;
		logic       obusy;
	} sts_t;

	function automatic logic [63:0] sat_q(logic [PROD_W-1:0] q, logic neg, int unsigned bits);
		logic [63:0] lim;
		logic [63:0] mag;
		logic        ov;
		lim = 64'd1 << (bits - 1);
		ov  = (|q[PROD_W-1:64]) || (q[63:0] >= lim);
		mag = ov ? (neg ? lim : lim - 64'd1) : q[63:0];
		return neg ? (64'd0 - mag) : mag;
	endfunction

endpackage

[rtl/lscal_mul.sv]
// Serial signed shift-add multiplier, one multiplier bit per cycle.
module lscal_mul (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 go,
	input  logic [lscal_pkg::MUL_A_W-1:0]        a,
	input  logic [lscal_pkg::MUL_B_W-1:0]        b,
	output logic                                 done,
	output logic [lscal_pkg::PROD_W-1:0]         p
);
	import lscal_pkg::*;

	localparam int unsigned HI_W = MUL_A_W + 2;
	localparam int unsigned CW   = $clog2(MUL_B_W);

	logic [HI_W-1:0]    hi_q;
	logic [MUL_B_W-1:0] lo_q;
	logic [MUL_A_W-1:0] a_q;
	logic [CW-1:0]      cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [HI_W-1:0]    a_ext;
	logic [HI_W-1:0]    addend;
	logic [HI_W-1:0]    sum;
	logic               last;

	assign last   = (cnt_q == CW'(MUL_B_W - 1));
	assign a_ext  = {{2{a_q[MUL_A_W-1]}}, a_q};
	assign addend = lo_q[0] ? (last ? (HI_W'(0) - a_ext) : a_ext) : HI_W'(0);
	assign sum    = hi_q + addend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= {sum[HI_W-1], sum[HI_W-1:1]};
			lo_q <= {sum[0], lo_q[MUL_B_W-1:1]};
		end
	end

	assign done = done_q;
	assign p    = PROD_W'({hi_q, lo_q});
endmodule

[rtl/lscal_div.sv]
// Restoring divider giving the rounded quotient magnitude of a signed numerator.
module lscal_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic [lscal_pkg::PROD_W-1:0]  num,
	input  logic [lscal_pkg::DEN_W-1:0]   den,
	output logic                          done,
	output logic                          neg,
	output logic [lscal_pkg::PROD_W-1:0]  q
);
	import lscal_pkg::*;

	localparam int unsigned CW = $clog2(PROD_W);
	localparam int unsigned RW = DEN_W + 2;

	logic [PROD_W-1:0] n_q;
	logic [RW-2:0]     d2_q;
	logic [RW-2:0]     r_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic              neg_q;
	logic [PROD_W-1:0] mag;
	logic [RW-1:0]     rs;
	logic              ge;
	logic              last;

	assign last = (cnt_q == CW'(PROD_W - 1));
	assign mag  = num[PROD_W-1] ? (PROD_W'(0) - num) : num;
	assign rs   = {r_q, n_q[PROD_W-1]};
	assign ge   = (rs >= {1'b0, d2_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			neg_q <= num[PROD_W-1];
			n_q   <= {mag[PROD_W-2:0], 1'b0} + {{(PROD_W-DEN_W){1'b0}}, den};
			d2_q  <= {den, 1'b0};
			r_q   <= '0;
		end else if (busy_q) begin
			r_q <= ge ? (RW-1)'(rs - {1'b0, d2_q}) : rs[RW-2:0];
			n_q <= {n_q[PROD_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign neg  = neg_q;
	assign q    = n_q;
endmodule

[rtl/lscal_dp.sv]
// Datapath: running sums, line registers, shared multiplier and divider, result register.
module lscal_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lscal_pkg::cmd_t       cmd,
	output lscal_pkg::sts_t       sts,
	input  logic [2:0]            in_action,
	input  logic [143:0]          in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            out_user,
	output logic [127:0]          out_data
);
	import lscal_pkg::*;

	logic [2:0]         act_q;
	logic [23:0]        count_q;
	logic [31:0]        mass_q;
	logic [47:0]        slin_q;
	logic [39:0]        icin_q;
	logic [27:0]        sc_q;
	logic [35:0]        sw_q;
	logic [63:0]        scw_q;
	logic [63:0]        sc2_q;
	logic [TOT_W-1:0]   tot_q;
	logic [47:0]        slope_q;
	logic [39:0]        icpt_q;
	logic [31:0]        weight_q;
	logic [1:0]         st_q;
	logic [PROD_W-1:0]  t1_q;
	logic [PROD_W-1:0]  t2_q;
	logic [1:0]         dsel_q;
	logic               ov_q;
	logic [1:0]         ost_q;
	logic [127:0]       odata_q;

	logic [MUL_A_W-1:0] ma;
	logic [MUL_B_W-1:0] mb;
	logic               mdone;
	logic [PROD_W-1:0]  p;
	logic [PROD_W-1:0]  dnum;
	logic [DEN_W-1:0]   dden;
	logic               ddone;
	logic               dneg;
	logic [PROD_W-1:0]  dq;
	logic [63:0]        dres;
	logic [PROD_W-1:0]  cv_sum;
	logic               cv_ov;
	logic [31:0]        cv_res;

	always_comb begin
		case (cmd.mul_sel)
			M_CW: begin
				ma = {{32{mass_q[31]}}, mass_q};
				mb = {{12{count_q[23]}}, count_q};
			end
			M_CC: begin
				ma = {{40{count_q[23]}}, count_q};
				mb = {{12{count_q[23]}}, count_q};
			end
			M_NC2: begin
				ma = sc2_q;
				mb = MUL_B_W'(tot_q);
			end
			M_SCSC: begin
				ma = {{36{sc_q[27]}}, sc_q};
				mb = {{8{sc_q[27]}}, sc_q};
			end
			M_NCW: begin
				ma = scw_q;
				mb = MUL_B_W'(tot_q);
			end
			M_SCSW: begin
				ma = {{28{sw_q[35]}}, sw_q};
				mb = {{8{sc_q[27]}}, sc_q};
			end
			M_SLSC: begin
				ma = {{16{slope_q[47]}}, slope_q};
				mb = {{8{sc_q[27]}}, sc_q};
			end
			default: begin
				ma = {{16{slope_q[47]}}, slope_q};
				mb = {{12{count_q[23]}}, count_q};
			end
		endcase
	end

	lscal_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.mul_go),
		.a      (ma),
		.b      (mb),
		.done   (mdone),
		.p      (p)
	);

	always_comb begin
		case (cmd.div_sel)
			D_SLOPE: begin
				dnum = {t2_q[PROD_W-33:0], 32'd0};
				dden = t1_q[DEN_W-1:0];
			end
			default: begin
				dnum = t2_q;
				dden = {{(DEN_W-TOT_W-24){1'b0}}, tot_q, 24'd0};
			end
		endcase
	end

	lscal_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.div_go),
		.num    (dnum),
		.den    (dden),
		.done   (ddone),
		.neg    (dneg),
		.q      (dq)
	);

	always_comb begin
		case (dsel_q)
			D_SLOPE: dres = sat_q(dq, dneg, 48);
			default: dres = sat_q(dq, dneg, 40);
		endcase
	end

	// round half away from zero on a division by 2^32, then clamp to 32 bits
	assign cv_sum = t2_q + {{(PROD_W-32){1'b0}}, 32'h8000_0000}
		- {{(PROD_W-1){1'b0}}, t2_q[PROD_W-1]};
	assign cv_ov  = (|cv_sum[PROD_W-1:63]) && !(&cv_sum[PROD_W-1:63]);
	assign cv_res = cv_ov ? (cv_sum[PROD_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF)
		: cv_sum[63:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_q   <= '0;
			slope_q <= '0;
			icpt_q  <= '0;
			sc_q    <= '0;
			sw_q    <= '0;
			scw_q   <= '0;
			sc2_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (cmd.clr_tot) begin
				tot_q <= '0;
				sc_q  <= '0;
				sw_q  <= '0;
				scw_q <= '0;
				sc2_q <= '0;
			end
			if (cmd.acc_en && cmd.acc_op == A_SCW) begin
				scw_q <= scw_q + p[63:0];
			end
			if (cmd.acc_en && cmd.acc_op == A_ADDPT) begin
				sc2_q <= sc2_q + p[63:0];
				sc_q  <= sc_q + {{4{count_q[23]}}, count_q};
				sw_q  <= sw_q + {{4{mass_q[31]}}, mass_q};
				tot_q <= tot_q + TOT_W'(1);
			end
			if (cmd.load) begin
				slope_q <= slin_q;
				icpt_q  <= icin_q;
			end
			if (ddone && dsel_q == D_SLOPE) begin
				slope_q <= dres[47:0];
			end
			if (ddone && dsel_q == D_ICPT) begin
				icpt_q <= dres[39:0];
			end
			if (cmd.pub) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			act_q    <= in_action;
			count_q  <= in_data[23:0];
			mass_q   <= in_data[55:24];
			slin_q   <= in_data[103:56];
			icin_q   <= in_data[143:104];
			weight_q <= '0;
			st_q     <= ST_OK;
		end
		if (cmd.set_st) begin
			st_q <= cmd.st;
		end
		if (cmd.div_go) begin
			dsel_q <= cmd.div_sel;
		end
		if (cmd.conv) begin
			weight_q <= cv_res;
		end
		if (cmd.acc_en) begin
			case (cmd.acc_op)
				A_T1:    t1_q <= p;
				A_T1SUB: t1_q <= t1_q - p;
				A_T2:    t2_q <= p;
				A_T2SUB: t2_q <= t2_q - p;
				A_IC:    t2_q <= ({{(PROD_W-36){sw_q[35]}}, sw_q} << 32) - p;
				A_CV:    t2_q <= p + ({{(PROD_W-40){icpt_q[39]}}, icpt_q} << 24);
				default: begin
				end
			endcase
		end
		if (cmd.pub) begin
			ost_q   <= st_q;
			odata_q <= {3'd0, tot_q, icpt_q, slope_q, weight_q};
		end
	end

	assign sts.action = act_q;
	assign sts.mdone  = mdone;
	assign sts.ddone  = ddone;
	assign sts.full   = (tot_q == TOT_W'(MAX_POINTS));
	assign sts.few    = (tot_q < TOT_W'(2));
	assign sts.den0   = (t1_q == '0);
	assign sts.obusy  = ov_q;

	assign out_valid = ov_q;
	assign out_user  = ost_q;
	assign out_data  = odata_q;
endmodule

[rtl/lscal_ctrl.sv]
// Controller: sequences multiplies and divides for the add, fit and convert actions.
module lscal_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  lscal_pkg::sts_t sts,
	input  logic            out_ready,
	output lscal_pkg::cmd_t cmd
);
	import lscal_pkg::*;

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_DEC    = 5'd1;
	localparam logic [4:0] S_W_CW   = 5'd2;
	localparam logic [4:0] S_W_CC   = 5'd3;
	localparam logic [4:0] S_W_NC2  = 5'd4;
	localparam logic [4:0] S_W_SCSC = 5'd5;
	localparam logic [4:0] S_ZCHK   = 5'd6;
	localparam logic [4:0] S_W_NCW  = 5'd7;
	localparam logic [4:0] S_W_SCSW = 5'd8;
	localparam logic [4:0] S_DSL    = 5'd9;
	localparam logic [4:0] S_W_DS   = 5'd10;
	localparam logic [4:0] S_MSL    = 5'd11;
	localparam logic [4:0] S_W_SLSC = 5'd12;
	localparam logic [4:0] S_DIC    = 5'd13;
	localparam logic [4:0] S_W_DI   = 5'd14;
	localparam logic [4:0] S_W_CV   = 5'd15;
	localparam logic [4:0] S_DCV    = 5'd16;
	localparam logic [4:0] S_DONE   = 5'd17;

	logic [4:0] state_q;
	logic [4:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				case (sts.action)
					ACT_ADD: begin
						if (sts.full) begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_FULL;
							state_d    = S_DONE;
						end else begin
							cmd.mul_go  = 1'b1;
							cmd.mul_sel = M_CW;
							state_d     = S_W_CW;
						end
					end
					ACT_RESET: begin
						cmd.clr_tot = 1'b1;
						state_d     = S_DONE;
					end
					ACT_FIT: begin
						if (sts.few) begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_FEW;
							state_d    = S_DONE;
						end else begin
							cmd.mul_go  = 1'b1;
							cmd.mul_sel = M_NC2;
							state_d     = S_W_NC2;
						end
					end
					ACT_CONV: begin
						cmd.mul_go  = 1'b1;
						cmd.mul_sel = M_SLCNT;
						state_d     = S_W_CV;
					end
					ACT_LOAD: begin
						cmd.load = 1'b1;
						state_d  = S_DONE;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_W_CW: begin
				if (sts.mdone) begin
					cmd.acc_en  = 1'b1;
					cmd.acc_op  = A_SCW;
					cmd.mul_go  = 1'b1;
					cmd.mul_sel = M_CC;
					state_d     = S_W_CC;
				end
			end
			S_W_CC: begin
				if (sts.mdone) begin
					cmd.acc_en = 1'b1;
					cmd.acc_op = A_ADDPT;
					state_d    = S_DONE;
				end
			end
			S_W_NC2: begin
				if (sts.mdone) begin
					cmd.acc_en  = 1'b1;
					cmd.acc_op  = A_T1;
					cmd.mul_go  = 1'b1;
					cmd.mul_sel = M_SCSC;
					state_d     = S_W_SCSC;
				end
			end
			S_W_SCSC: begin
				if (sts.mdone) begin
					cmd.acc_en = 1'b1;
					cmd.acc_op = A_T1SUB;
					state_d    = S_ZCHK;
				end
			end
			S_ZCHK: begin
				if (sts.den0) begin
					cmd.set_st = 1'b1;
					cmd.st     = ST_DEN0;
					state_d    = S_DONE;
				end else begin
					cmd.mul_go  = 1'b1;
					cmd.mul_sel = M_NCW;
					state_d     = S_W_NCW;
				end
			end
			S_W_NCW: begin
				if (sts.mdone) begin
					cmd.acc_en  = 1'b1;
					cmd.acc_op  = A_T2;
					cmd.mul_go  = 1'b1;
					cmd.mul_sel = M_SCSW;
					state_d     = S_W_SCSW;
				end
			end
			S_W_SCSW: begin
				if (sts.mdone) begin
					cmd.acc_en = 1'b1;
					cmd.acc_op = A_T2SUB;
					state_d    = S_DSL;
				end
			end
			S_DSL: begin
				cmd.div_go  = 1'b1;
				cmd.div_sel = D_SLOPE;
				state_d     = S_W_DS;
			end
			S_W_DS: begin
				if (sts.ddone) begin
					state_d = S_MSL;
				end
			end
			S_MSL: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = M_SLSC;
				state_d     = S_W_SLSC;
			end
			S_W_SLSC: begin
				if (sts.mdone) begin
					cmd.acc_en = 1'b1;
					cmd.acc_op = A_IC;
					state_d    = S_DIC;
				end
			end
			S_DIC: begin
				cmd.div_go  = 1'b1;
				cmd.div_sel = D_ICPT;
				state_d     = S_W_DI;
			end
			S_W_DI: begin
				if (sts.ddone) begin
					state_d = S_DONE;
				end
			end
			S_W_CV: begin
				if (sts.mdone) begin
					cmd.acc_en = 1'b1;
					cmd.acc_op = A_CV;
					state_d    = S_DCV;
				end
			end
			S_DCV: begin
				cmd.conv = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				if (!sts.obusy || out_ready) begin
					cmd.pub = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

[rtl/least_squares_line_calibrator_top.sv]
// Top level of the least-squares line calibrator.
// One item at a time; the result leaves through an output register, so the next item is taken
// while a result still waits. Reset, load, undefined actions, an add to a full store and a fit
// with fewer than two points need no arithmetic. An added point takes two passes of the serial
// multiplier (36 steps each); a convert takes one multiply, then a step to round and clamp; a
// fit takes five multiplies and two passes of the one-bit-a-step divider, or only two multiplies
// when the denominator is zero. Any item waits to publish its result while the output register
// is still full and m_tready is low.
// Points are kept as running sums of count, mass, count*mass and count squared.
module least_squares_line_calibrator_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [2:0]   s_tuser,  // action
	input  logic [143:0] s_tdata,  // sample_count, known_mass, slope_in, intercept_in
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [1:0]   m_tuser,  // status
	output logic [127:0] m_tdata   // weight, slope, intercept, points_held, zero pad
);
	import lscal_pkg::*;

	cmd_t cmd;
	sts_t sts;

	lscal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.sts       (sts),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	lscal_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_action (s_tuser),
		.in_data   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_user  (m_tuser),
		.out_data  (m_tdata)
	);

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken again before the item finished");

	a_points_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[124:120] <= TOT_W'(MAX_POINTS)))
		else $error("points held beyond store depth");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_FULL) |-> (m_tdata[124:120] == TOT_W'(MAX_POINTS)))
		else $error("store full reported with free entries");
endmodule

[tb/least_squares_line_calibrator_checker.sv]
`timescale 1ns / 100ps
// Result predictor and scoreboard for the least-squares line calibrator.
module least_squares_line_calibrator_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [2:0]   s_tuser,
	input  logic [143:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [1:0]   m_tuser,
	input  logic [127:0] m_tdata,
	output int           mismatches,
	output int           pending,
	output int           results_seen,
	output int           fits_ok
);
	import lscal_pkg::*;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] weight;
		logic [47:0] slope;
		logic [39:0] intercept;
		logic [4:0]  points_held;
	} cal_result_t;

	cal_result_t        expected_q[$];
	logic signed [23:0] cal_counts[MAX_POINTS];
	logic signed [31:0] cal_masses[MAX_POINTS];
	int unsigned        cal_total;
	logic signed [47:0] cur_slope;
	logic signed [39:0] cur_icpt;

	function automatic logic signed [63:0] round_sat(logic signed [127:0] num,
			logic [127:0] den, int bits);
		logic          neg;
		logic [127:0]  mag;
		logic [127:0]  q;
		logic [127:0]  lim;
		neg = num[127];
		mag = neg ? -num : num;
		q   = (mag * 2 + den) / (den * 2);
		lim = 128'd1 << (bits - 1);
		if (q >= lim)
			q = neg ? lim : lim - 1;
		return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
	endfunction

	function automatic logic [1:0] fit_line();
		longint             sc, sw, scw, sc2, n, den;
		logic signed [127:0] num;
		logic signed [63:0]  r;
		sc = 0; sw = 0; scw = 0; sc2 = 0;
		if (cal_total < 2)
			return ST_FEW;
		for (int i = 0; i < cal_total; i++) begin
			sc  += longint'(cal_counts[i]);
			sw  += longint'(cal_masses[i]);
			scw += longint'(cal_counts[i]) * longint'(cal_masses[i]);
			sc2 += longint'(cal_counts[i]) * longint'(cal_counts[i]);
		end
		n   = cal_total;
		den = n * sc2 - sc * sc;
		if (den == 0)
			return ST_DEN0;
		num = ((128'(signed'(n)) * 128'(signed'(scw))) -
			(128'(signed'(sc)) * 128'(signed'(sw)))) <<< 32;
		r = round_sat(num, 128'(den), 48);
		cur_slope = r[47:0];
		num = (128'(signed'(sw)) <<< 32) - (128'(cur_slope) * 128'(signed'(sc)));
		r = round_sat(num, 128'(n) << 24, 40);
		cur_icpt = r[39:0];
		return ST_OK;
	endfunction

	function automatic cal_result_t predict_item(logic [2:0] act, logic [143:0] d);
		cal_result_t        res;
		logic signed [23:0] cnt;
		logic signed [127:0] num;
		logic signed [63:0]  r;
		res = '0;
		cnt = d[23:0];
		case (act)
			ACT_ADD: begin
				if (cal_total < MAX_POINTS) begin
					cal_counts[cal_total] = cnt;
					cal_masses[cal_total] = d[55:24];
					cal_total++;
				end else begin
					res.status = ST_FULL;
				end
			end
			ACT_RESET: cal_total = 0;
			ACT_FIT: begin
				res.status = fit_line();
				if (res.status == ST_OK)
					fits_ok++;
			end
			ACT_CONV: begin
				num = (128'(cur_slope) * 128'(cnt)) + (128'(cur_icpt) <<< 24);
				r = round_sat(num, 128'd1 << 32, 32);
				res.weight = r[31:0];
			end
			ACT_LOAD: begin
				cur_slope = d[103:56];
				cur_icpt  = d[143:104];
			end
			default: ;
		endcase
		res.slope       = cur_slope;
		res.intercept   = cur_icpt;
		res.points_held = cal_total[4:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cal_result_t got, want;
		if (!arst_n) begin
			expected_q.delete();
			cal_total     = 0;
			cur_slope     = '0;
			cur_icpt      = '0;
			fits_ok       = 0;
			pending       = 0;
			mismatches   <= 0;
			results_seen <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = {m_tuser, m_tdata[31:0], m_tdata[79:32], m_tdata[119:80],
					m_tdata[124:120]};
				results_seen <= results_seen + 1;
				if (expected_q.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result %h", got);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						if (mismatches < 10) begin
							$display("mismatch: expected st=%0d w=%h m=%h b=%h n=%0d",
								want.status, want.weight, want.slope, want.intercept,
								want.points_held);
							$display("          got      st=%0d w=%h m=%h b=%h n=%0d",
								got.status, got.weight, got.slope, got.intercept,
								got.points_held);
						end
						mismatches <= mismatches + 1;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_q.push_back(predict_item(s_tuser, s_tdata));
			pending = expected_q.size();
		end
	end

endmodule

[tb/least_squares_line_calibrator_top_test.sv]
`timescale 1ns / 100ps
// Stimulus and verdict for the least-squares line calibrator.
module least_squares_line_calibrator_top_test;
	import lscal_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [2:0]   s_tuser;
	logic [143:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [1:0]   m_tuser;
	logic [127:0] m_tdata;
	int           mismatches, pending, results_seen, fits_ok;
	int           items_sent;
	logic         calm;

	least_squares_line_calibrator_top dut (.*);

	least_squares_line_calibrator_checker scoreboard (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	initial begin
		int hold;
		hold = 0;
		m_tready = 0;
		calm = 0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 399) == 0)
				calm = ~calm;
			if (hold > 0) begin
				hold--;
				m_tready = 0;
			end else begin
				m_tready = 1;
				hold = ($urandom_range(0, 3) == 0) ? idle_len() : 0;
			end
		end
	end

	task automatic send(logic [2:0] act, logic [23:0] cnt, logic [31:0] mass,
			logic [47:0] sl, logic [39:0] ic);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			s_tvalid = 0;
			repeat (gap) @(negedge clk);
		end
		s_tuser  = act;
		s_tdata  = {ic, sl, mass, cnt};
		s_tvalid = 1;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		@(negedge clk);
	endtask

	function automatic logic [47:0] rnd48();
		return 48'({$urandom, $urandom});
	endfunction

	function automatic logic [39:0] rnd40();
		return 40'({$urandom, $urandom});
	endfunction

	function automatic logic [23:0] rnd24();
		return 24'($urandom);
	endfunction

	task automatic send_rand(logic [2:0] act, logic [23:0] cnt, logic [31:0] mass);
		send(act, cnt, mass, rnd48(), rnd40());
	endtask

	task automatic send_load(logic [47:0] sl, logic [39:0] ic);
		send(ACT_LOAD, rnd24(), $urandom, sl, ic);
	endtask

	function automatic logic [23:0] rnd_count();
		case ($urandom_range(0, 3))
			0: return 24'($urandom);
			1: return 24'($signed($urandom_range(0, 2000)) - 1000);
			2: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
			default: return 24'($signed($urandom_range(0, 200000)) - 100000);
		endcase
	endfunction

	initial begin
		int               npts, nconv, base_c;
		logic signed [31:0] gain, offs;
		logic [23:0]      c;
		items_sent = 0;
		arst_n   = 0;
		s_tvalid = 0;
		s_tuser  = '0;
		s_tdata  = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		send_rand(ACT_FIT, rnd24(), $urandom);
		send_rand(ACT_CONV, 24'h7FFFFF, $urandom);
		send_rand(ACT_ADD, 24'd100, 32'd500);
		send_rand(ACT_FIT, rnd24(), $urandom);
		send_rand(ACT_ADD, 24'd100, 32'd900);
		send_rand(ACT_FIT, rnd24(), $urandom);
		send_rand(ACT_ADD, 24'h800000, 32'h80000000);
		send_rand(ACT_ADD, 24'h7FFFFF, 32'h7FFFFFFF);
		send_rand(ACT_FIT, rnd24(), $urandom);
		send_rand(ACT_CONV, 24'h800000, $urandom);
		send_rand(ACT_CONV, 24'h7FFFFF, $urandom);
		send_load(48'h7FFF_FFFF_FFFF, 40'h7F_FFFF_FFFF);
		send_rand(ACT_CONV, 24'h7FFFFF, $urandom);
		send_rand(ACT_CONV, 24'h800000, $urandom);
		send_load(48'h8000_0000_0000, 40'h80_0000_0000);
		send_rand(ACT_CONV, 24'h7FFFFF, $urandom);
		send_rand(ACT_CONV, 24'd0, $urandom);
		send_rand(3'd5, rnd24(), $urandom);
		send_rand(3'd6, rnd24(), $urandom);
		send_rand(3'd7, rnd24(), $urandom);
		send_rand(ACT_RESET, rnd24(), $urandom);
		for (int i = 0; i < 17; i++)
			send_rand(ACT_ADD, (i % 2) ? 24'h7FFFFF : 24'h800000,
				(i % 2) ? 32'h80000000 : 32'h7FFFFFFF);
		send_rand(ACT_FIT, rnd24(), $urandom);

		while (items_sent < 1350) begin
			if ($urandom_range(0, 5) == 0) begin
				send_rand(3'($urandom), rnd_count(), $urandom);
				continue;
			end
			send_rand(ACT_RESET, rnd24(), $urandom);
			npts   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 18)
				: $urandom_range(2, 6);
			gain   = $signed($urandom_range(0, 4000)) - 2000;
			offs   = $urandom;
			base_c = $urandom_range(0, 3) == 0 ? 1 : 0;
			for (int i = 0; i < npts; i++) begin
				c = base_c ? 24'd4242 : rnd_count();
				if ($urandom_range(0, 2) == 0)
					send_rand(ACT_ADD, c, $urandom);
				else
					send_rand(ACT_ADD, c, 32'(gain * $signed(c) + offs)
						+ 32'($urandom_range(0, 20)));
			end
			send_rand(ACT_FIT, rnd24(), $urandom);
			if ($urandom_range(0, 4) == 0)
				send_load(rnd48(), rnd40());
			nconv = $urandom_range(1, 5);
			repeat (nconv)
				send_rand(ACT_CONV, rnd_count(), $urandom);
		end
		@(negedge clk);
		s_tvalid = 0;

		while (pending != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		$display("Sent %0d items, checked %0d results, %0d successful fits.",
			items_sent, results_seen, fits_ok);
		$display("Covered adds to a full store, short and degenerate fits, loads and converts.");
		if (mismatches == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[files.f]
rtl/lscal_pkg.sv
rtl/lscal_mul.sv
rtl/lscal_div.sv
rtl/lscal_dp.sv
rtl/lscal_ctrl.sv
rtl/least_squares_line_calibrator_top.sv
tb/least_squares_line_calibrator_checker.sv
tb/least_squares_line_calibrator_top_test.sv
